@@ src/tom_pkg.sv @@
// Package with the beat types and reset constants of the thermal over-temperature monitor.
`default_nettype none
package tom_pkg;

   localparam int CHANNELS_DEF         = 8;
   localparam int OVER_TEMP_LIMIT_DEF  = 3;
   localparam int READ_ERROR_LIMIT_DEF = 3;
   localparam int NUM_LIMIT_REGS       = 8;
   localparam int CSR_INDEX_W          = 3;
   localparam int CSR_DATA_W           = 16;

   typedef logic signed [15:0] temp_type;

   localparam temp_type LIMIT_RESET [NUM_LIMIT_REGS] = '{
      16'sd1520, 16'sd1600, 16'sd1440, 16'sd1440,
      16'sd1440, 16'sd1440, 16'sd1520, 16'sd1200
   };

   typedef struct packed {
      logic [2:0] channel;
      temp_type   temperature;
      logic       reading_valid;
   } req_type;

   typedef struct packed {
      logic [7:0] overtemp_errors;
      logic       read_warning;
      logic [7:0] populated_mask;
      logic [1:0] channel_count;
   } rsp_type;

endpackage
`default_nettype wire

@@ src/tom_read_health.sv @@
// Shared read-error counter and the read warning with set and clear hysteresis.
`default_nettype none
module tom_read_health #(
   parameter int READ_ERROR_LIMIT = tom_pkg::READ_ERROR_LIMIT_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic update,
   input  wire logic reading_valid,
   output logic      warning_in
);
   import tom_pkg::*;

   localparam int RW = $clog2(READ_ERROR_LIMIT + 1);
   localparam logic [RW-1:0] RMAX = RW'(READ_ERROR_LIMIT);

   logic [RW-1:0] err_cnt_ff;
   logic [RW-1:0] err_cnt_upd;
   logic [RW-1:0] err_cnt_in;
   logic          warning_ff;

   always_comb begin
      if (reading_valid) begin
         err_cnt_upd = (err_cnt_ff == '0) ? err_cnt_ff : err_cnt_ff - RW'(1);
      end else begin
         err_cnt_upd = (err_cnt_ff == RMAX) ? err_cnt_ff : err_cnt_ff + RW'(1);
      end
      err_cnt_in = update ? err_cnt_upd : err_cnt_ff;
      priority if (err_cnt_upd == RMAX) begin
         warning_in = 1'b1;
      end else if (err_cnt_upd == '0) begin
         warning_in = 1'b0;
      end else begin
         warning_in = warning_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_cnt_ff <= '0;
         warning_ff <= 1'b0;
      end else if (update) begin
         err_cnt_ff <= err_cnt_in;
         warning_ff <= warning_in;
      end
   end

endmodule
`default_nettype wire

@@ src/tom_channel_state.sv @@
// Per-channel limits, saturating over-temperature counters, error latches and populated bits.
`default_nettype none
module tom_channel_state #(
   parameter int CHANNELS        = tom_pkg::CHANNELS_DEF,
   parameter int OVER_TEMP_LIMIT = tom_pkg::OVER_TEMP_LIMIT_DEF,
   localparam int CW             = $clog2(OVER_TEMP_LIMIT + 1)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                update,
   input  wire tom_pkg::req_type                    item,
   input  wire logic                                csr_we,
   input  wire logic [tom_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [tom_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic [CHANNELS-1:0]                      errors_in,
   output logic [CHANNELS-1:0]                      populated_in,
   output logic [CW-1:0]                            count_out
);
   import tom_pkg::*;

   localparam logic [CW-1:0] CMAX = CW'(OVER_TEMP_LIMIT);

   temp_type          limit_ff   [CHANNELS];
   logic [CW-1:0]     cnt_ff     [CHANNELS];
   logic [CW-1:0]     cnt_upd    [CHANNELS];
   logic [CHANNELS-1:0] sel;
   logic [CHANNELS-1:0] errors_ff;
   logic [CHANNELS-1:0] populated_ff;

   for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
      logic over;
      logic [CW-1:0] stepped;

      assign sel[i] = (32'(item.channel) == i);
      assign over   = (item.temperature >= limit_ff[i]);

      always_comb begin
         if (over) begin
            stepped = (cnt_ff[i] == CMAX) ? cnt_ff[i] : cnt_ff[i] + CW'(1);
         end else begin
            stepped = (cnt_ff[i] == '0) ? cnt_ff[i] : cnt_ff[i] - CW'(1);
         end
         cnt_upd[i] = (sel[i] && item.reading_valid) ? stepped : cnt_ff[i];
         errors_in[i]    = errors_ff[i] | (cnt_upd[i] == CMAX);
         populated_in[i] = populated_ff[i] | (sel[i] && item.reading_valid);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cnt_ff[i] <= '0;
         end else if (update) begin
            cnt_ff[i] <= cnt_upd[i];
         end
      end

      if (i < NUM_LIMIT_REGS) begin : g_reg
         always_ff @(posedge clock) begin
            if (reset) begin
               limit_ff[i] <= LIMIT_RESET[i];
            end else if (csr_we && (32'(csr_index) == i)) begin
               limit_ff[i] <= temp_type'(csr_wdata);
            end
         end
      end else begin : g_noreg
         always_ff @(posedge clock) begin
            if (reset) begin
               limit_ff[i] <= '0;
            end
         end
      end
   end

   always_comb begin
      count_out = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         count_out = count_out | (sel[i] ? cnt_upd[i] : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         errors_ff    <= '0;
         populated_ff <= '0;
      end else if (update) begin
         errors_ff    <= errors_in;
         populated_ff <= populated_in;
      end
   end

endmodule
`default_nettype wire

@@ src/thermal_overtemp_monitor.sv @@
// Top level of the thermal over-temperature monitor: input register, state update, result register.
// An accepted beat goes through the input register, then the result register.
// Throughput: one beat per cycle while the output is not stalled; the compare and counter
// step sit between the input register and the result register.
// Reset is synchronous and active high; counters, latches, flags and limits take their
// reset values with no clearing pass.
`default_nettype none
module thermal_overtemp_monitor #(
   parameter int CHANNELS         = tom_pkg::CHANNELS_DEF,
   parameter int OVER_TEMP_LIMIT  = tom_pkg::OVER_TEMP_LIMIT_DEF,
   parameter int READ_ERROR_LIMIT = tom_pkg::READ_ERROR_LIMIT_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire tom_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output tom_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [tom_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tom_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tom_pkg::*;

   localparam int CW   = $clog2(OVER_TEMP_LIMIT + 1);
   localparam int MW   = (CHANNELS > 8) ? CHANNELS : 8;
   localparam int CWW  = (CW > 2) ? CW : 2;

   logic                s1_valid_ff;
   logic                s1_valid_in;
   req_type             s1_data_ff;
   logic                s1_move;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_type             rsp_data_ff;
   rsp_type             rsp_data_in;
   logic [CHANNELS-1:0] errors_in;
   logic [CHANNELS-1:0] populated_in;
   logic [CW-1:0]       count_out;
   logic                warning_in;
   logic [MW-1:0]       errors_wide;
   logic [MW-1:0]       populated_wide;
   logic [CWW-1:0]      count_wide;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && rsp_valid_ff && rsp_stall;

   tom_channel_state #(
      .CHANNELS        (CHANNELS),
      .OVER_TEMP_LIMIT (OVER_TEMP_LIMIT)
   ) u_channels (
      .clock        (clock),
      .reset        (reset),
      .update       (s1_move),
      .item         (s1_data_ff),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .errors_in    (errors_in),
      .populated_in (populated_in),
      .count_out    (count_out)
   );

   tom_read_health #(
      .READ_ERROR_LIMIT (READ_ERROR_LIMIT)
   ) u_health (
      .clock         (clock),
      .reset         (reset),
      .update        (s1_move),
      .reading_valid (s1_data_ff.reading_valid),
      .warning_in    (warning_in)
   );

   always_comb begin
      errors_wide    = MW'(errors_in);
      populated_wide = MW'(populated_in);
      count_wide     = CWW'(count_out);
      rsp_data_in.overtemp_errors = errors_wide[7:0];
      rsp_data_in.read_warning    = warning_in;
      rsp_data_in.populated_mask  = populated_wide[7:0];
      rsp_data_in.channel_count   = count_wide[1:0];
      s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
      rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_data_ff <= req_data;
      end
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_err_populated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.overtemp_errors & ~rsp_data.populated_mask) == 8'd0))
      else $error("Error bit set for a channel that was never populated.");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("Input stalled with no beat held in the pipeline.");

   a_move_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid)
      else $error("A beat left the input register but no result beat followed.");

   a_errors_sticky: assert property (@(posedge clock) disable iff (reset)
      (s1_move && $past(s1_move) && !$past(reset)) |=>
         ((rsp_data.overtemp_errors & $past(rsp_data.overtemp_errors))
          == $past(rsp_data.overtemp_errors)))
      else $error("A latched error bit was cleared.");
`endif

endmodule
`default_nettype wire

@@ tb/thermal_overtemp_monitor_test.sv @@
// Self-checking testbench for the thermal over-temperature monitor, with random readings and stalls.
module thermal_overtemp_monitor_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tom_pkg::*;

   localparam int QUIET_LIMIT = 2000;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   thermal_overtemp_monitor i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted monitor state.
   temp_type   limit_reg [NUM_LIMIT_REGS];
   temp_type   limit_plan [NUM_LIMIT_REGS];
   logic [1:0] heat_count [CHANNELS_DEF] = '{default: 2'd0};
   logic [1:0] read_fail_count = 2'd0;
   logic [7:0] err_latch = 8'd0;
   logic       warn = 1'b0;
   logic [7:0] seen_mask = 8'd0;

   req_type reading_queue [$];
   rsp_type due_status [$];

   int send_gap_max   = 0;
   int recv_stall_max = 0;
   int send_wait      = 0;
   int recv_wait      = 0;
   int fail_count     = 0;
   int readings_taken = 0;
   int status_seen    = 0;
   int warning_beats  = 0;
   int idle_cycles    = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic rsp_type apply_reading(req_type r);
      rsp_type    s;
      temp_type   t;
      logic [2:0] ch;
      ch = r.channel;
      t  = r.temperature;
      if (r.reading_valid) begin
         if (read_fail_count != 0) read_fail_count--;
         seen_mask[ch] = 1'b1;
         if (t >= limit_reg[ch]) begin
            if (heat_count[ch] != OVER_TEMP_LIMIT_DEF) heat_count[ch]++;
         end else if (heat_count[ch] != 0) begin
            heat_count[ch]--;
         end
         if (heat_count[ch] == OVER_TEMP_LIMIT_DEF) err_latch[ch] = 1'b1;
      end else if (read_fail_count != READ_ERROR_LIMIT_DEF) begin
         read_fail_count++;
      end
      if (read_fail_count == READ_ERROR_LIMIT_DEF) begin
         warn = 1'b1;
      end else if (read_fail_count == 0) begin
         warn = 1'b0;
      end
      s.overtemp_errors = err_latch;
      s.read_warning    = warn;
      s.populated_mask  = seen_mask;
      s.channel_count   = heat_count[ch];
      return s;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : reading_driver
      bit taken;
      taken = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (taken) begin
            due_status.push_back(apply_reading(req_data));
            readings_taken++;
         end
         if (!req_valid || taken) begin
            if (send_wait != 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (reading_queue.size() != 0) begin
               req_data  <= reading_queue.pop_front();
               req_valid <= 1'b1;
               send_wait = $urandom_range(0, send_gap_max);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : status_monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            status_seen++;
            if (rsp_data.read_warning) warning_beats++;
            if (due_status.size() == 0) begin
               $error("Status beat arrived with no reading outstanding: %p", rsp_data);
               fail_count++;
            end else begin
               want = due_status.pop_front();
               check_field("overtemp_errors", want.overtemp_errors, rsp_data.overtemp_errors);
               check_field("read_warning", want.read_warning, rsp_data.read_warning);
               check_field("populated_mask", want.populated_mask, rsp_data.populated_mask);
               check_field("channel_count", want.channel_count, rsp_data.channel_count);
            end
            recv_wait = $urandom_range(0, recv_stall_max);
         end
         if (recv_wait != 0) begin
            recv_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : quiet_watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= QUIET_LIMIT) begin
         $display("Watchdog expired after %0d cycles without a beat.", idle_cycles);
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_reading(logic [2:0] ch, int t, logic ok);
      req_type r;
      r.channel       = ch;
      r.temperature   = temp_type'(t);
      r.reading_valid = ok;
      reading_queue.push_back(r);
   endtask

   function automatic req_type draw_reading(logic [2:0] ch, int lean);
      req_type r;
      int      t;
      int      off;
      off = $urandom_range(0, 8);
      case ($urandom_range(0, 9))
         0, 1: t = int'($urandom_range(0, 65535)) - 32768;
         2: t = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
         default: t = int'(limit_reg[ch]) + off - 4 + lean;
      endcase
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      r.channel       = ch;
      r.temperature   = temp_type'(t);
      r.reading_valid = ($urandom_range(0, 5) != 0);
      return r;
   endfunction

   task automatic queue_random(int target);
      int         n;
      int         len;
      int         lean;
      logic [2:0] ch;
      req_type    r;
      n = 0;
      while (n < target) begin
         case ($urandom_range(0, 7))
            0: begin
               // A burst of failed reads drives the warning up to its limit.
               len = $urandom_range(3, 5);
               for (int k = 0; k < len; k++) begin
                  r = draw_reading(3'($urandom_range(0, 7)), 0);
                  r.reading_valid = 1'b0;
                  reading_queue.push_back(r);
               end
            end
            1, 2: begin
               // A run on one channel trending hot or cold walks its counter.
               len  = $urandom_range(3, 6);
               ch   = 3'($urandom_range(0, 7));
               lean = ($urandom_range(0, 1) != 0) ? 4 : -5;
               for (int k = 0; k < len; k++) reading_queue.push_back(draw_reading(ch, lean));
            end
            default: begin
               len = 1;
               reading_queue.push_back(draw_reading(3'($urandom_range(0, 7)), 0));
            end
         endcase
         n += len;
      end
   endtask

   task automatic program_limits();
      for (int i = 0; i < NUM_LIMIT_REGS; i++) begin
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_wdata <= limit_plan[i];
         limit_reg[i] = limit_plan[i];
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_quiet();
      while (reading_queue.size() != 0 || req_valid || due_status.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(int send_max, int recv_max, int count);
      program_limits();
      @(negedge clock);
      send_gap_max   = send_max;
      recv_stall_max = recv_max;
      queue_random(count);
      wait_quiet();
   endtask

   initial begin
      foreach (limit_reg[i]) limit_reg[i] = LIMIT_RESET[i];
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed readings against the reset limits.
      send_gap_max   = 3;
      recv_stall_max = 3;
      queue_reading(3'd0, 1520, 1'b1);
      queue_reading(3'd0, 1520, 1'b1);
      queue_reading(3'd0, 1520, 1'b1);
      queue_reading(3'd0, 1520, 1'b1);
      queue_reading(3'd0, 1519, 1'b1);
      queue_reading(3'd1, 32767, 1'b1);
      queue_reading(3'd1, -32768, 1'b1);
      queue_reading(3'd1, -32768, 1'b1);
      queue_reading(3'd2, 23130, 1'b0);
      queue_reading(3'd2, -21846, 1'b0);
      queue_reading(3'd2, 0, 1'b0);
      queue_reading(3'd2, -1, 1'b0);
      queue_reading(3'd0, 32767, 1'b0);
      queue_reading(3'd3, 0, 1'b1);
      queue_reading(3'd4, 1440, 1'b1);
      queue_reading(3'd5, 1439, 1'b1);
      queue_reading(3'd6, -1, 1'b1);
      queue_reading(3'd7, 1200, 1'b1);
      queue_reading(3'd7, 32767, 1'b1);
      queue_reading(3'd7, 1200, 1'b1);
      queue_reading(3'd5, -32768, 1'b0);
      wait_quiet();

      foreach (limit_plan[i]) limit_plan[i] = temp_type'($urandom_range(0, 65535));
      run_phase(14, 14, 226);
      foreach (limit_plan[i]) limit_plan[i] = 16'sh8000;
      run_phase(0, 0, 226);
      foreach (limit_plan[i]) limit_plan[i] = 16'sh7FFF;
      run_phase(14, 0, 226);
      foreach (limit_plan[i]) limit_plan[i] = temp_type'(int'($urandom_range(0, 2200)) - 200);
      run_phase(0, 14, 226);
      foreach (limit_plan[i]) limit_plan[i] = temp_type'($urandom_range(1200, 1600));
      run_phase(5, 5, 226);

      repeat (8) @(posedge clock);
      if (due_status.size() != 0) begin
         $error("%0d status beats never arrived", due_status.size());
         fail_count++;
      end
      $display("Sent %0d readings and checked %0d status beats over six limit settings.",
               readings_taken, status_seen);
      $display("Channels latched hot: %b; read warning seen on %0d beats.",
               err_latch, warning_beats);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/tom_pkg.sv
src/tom_read_health.sv
src/tom_channel_state.sv
src/thermal_overtemp_monitor.sv
tb/thermal_overtemp_monitor_test.sv
